FILE: rtl/kcs_pkg.sv
// Shared types, codes and arithmetic helpers of the keyframe channel sampler.
// No dependencies; every other file imports this package.
package kcs_pkg;

    localparam int WORDS_PER_KEY = 12;

    localparam logic [1:0] KIND_TIME  = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    localparam logic [1:0] MODE_STEP   = 2'd0;
    localparam logic [1:0] MODE_LINEAR = 2'd1;
    localparam logic [1:0] MODE_CUBIC  = 2'd2;

    localparam logic [1:0] CHAN_TRANS = 2'd0;
    localparam logic [1:0] CHAN_ROT   = 2'd1;
    localparam logic [1:0] CHAN_SCALE = 2'd2;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_CHAN  = 2'd1;
    localparam logic [1:0] REG_COUNT = 2'd2;
    localparam logic [1:0] REG_JOINT = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic [5:0]         key_index;
        logic [3:0]         slot;
        logic [31:0]        key_time;
        logic signed [31:0] key_value;
        logic [31:0]        query_time;
    } kcs_item_t;

    typedef struct packed {
        logic [7:0]         joint;
        logic [1:0]         component_index;
        logic signed [31:0] component_value;
        logic               last;
    } kcs_result_t;

    typedef enum logic [1:0] {
        OP_TIME,
        OP_VALUE,
        OP_QUERY
    } kcs_op_t;

    typedef struct packed {
        kcs_op_t     op;
        logic [5:0]  key;
        logic [3:0]  slot;
        logic [31:0] data;
    } kcs_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] chan;
        logic [6:0] key_count;
        logic [7:0] joint;
    } kcs_cfg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_DIV,
        S_BASIS,
        S_FETCH,
        S_MUL
    } kcs_state_t;

    // round half up, then drop s fraction bits
    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                        input int s);
        logic signed [63:0] bias;
        bias = 64'sd1 <<< (s - 1);
        return (v + bias) >>> s;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

FILE: rtl/keyframe_channel_sampler.sv
// Top level of the keyframe channel sampler: configuration registers,
// front end and back end. Depends on kcs_pkg, kcs_front and kcs_back.
//
// Usage:
//   Items enter on item when start is high and busy is low. Kind 0 and 1
//   items load a key time or a key value word; kind 2 items sample the
//   channel at query_time and make 0, 1, 3 or 4 results, one per component.
//   Each result appears on result for one cycle with result_valid high;
//   result.last marks the final component. The receiver cannot stall.
//   A two-entry command queue lets items arrive while a query runs; busy
//   is high while that queue is full.
//   A query takes the command from the queue, then reads and checks each
//   key visited by the linear key search over the time table, runs the
//   bit-serial span divider when the query falls between keys, sets up the
//   basis for cubic mode, then per component reads the value table and,
//   for linear or cubic mode between keys, works on the shared multiplier;
//   each result is registered before it shows on result.
//   The back end takes a write item from the queue and writes it in the
//   same cycle.
//   Configuration is written through cfg_we, cfg_index, cfg_data; it takes
//   effect at once and should change only while no query is in flight.
//   Reset clears the queue and control state and loads the register
//   defaults; the key tables are undefined until written.
module keyframe_channel_sampler #(
    parameter int MAX_KEYS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  kcs_pkg::kcs_item_t   item,
    output logic                 result_valid,
    output kcs_pkg::kcs_result_t result,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_data
);
    import kcs_pkg::*;

    kcs_cfg_t cfg_reg, cfg_next;
    logic     cmd_valid;
    kcs_cmd_t cmd;
    logic     cmd_pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:  cfg_next.mode      = cfg_data[1:0];
                REG_CHAN:  cfg_next.chan      = cfg_data[1:0];
                REG_COUNT: cfg_next.key_count = cfg_data[6:0];
                REG_JOINT: cfg_next.joint     = cfg_data;
                default:   cfg_next           = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode      <= MODE_LINEAR;
            cfg_reg.chan      <= CHAN_TRANS;
            cfg_reg.key_count <= 7'd1;
            cfg_reg.joint     <= 8'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    kcs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    kcs_back #(
        .MAX_KEYS (MAX_KEYS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .cfg          (cfg_reg),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

FILE: rtl/kcs_front.sv
// Front end: classifies incoming items into commands and queues them.
// Depends on kcs_pkg.
module kcs_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  kcs_pkg::kcs_item_t item,
    output logic              cmd_valid,
    output kcs_pkg::kcs_cmd_t cmd,
    input  logic              cmd_pop
);
    import kcs_pkg::*;

    kcs_cmd_t   q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    kcs_cmd_t   dec;
    logic       dec_ok;
    logic       push;
    logic       pop;

    always_comb
    begin
        dec.key  = item.key_index;
        dec.slot = item.slot;
        dec.op   = OP_QUERY;
        dec.data = item.query_time;
        dec_ok   = 1'b0;
        case (item.kind)
            KIND_TIME:
            begin
                dec.op   = OP_TIME;
                dec.data = item.key_time;
                dec_ok   = 1'b1;
            end
            KIND_VALUE:
            begin
                dec.op   = OP_VALUE;
                dec.data = item.key_value;
                // drop writes to slots past the key
                dec_ok   = item.slot < 4'(WORDS_PER_KEY);
            end
            KIND_QUERY:
            begin
                dec_ok = 1'b1;
            end
            default:
            begin
                dec_ok = 1'b0;
            end
        endcase
    end

    assign busy      = count_reg == 2'd2;
    assign push      = start && !busy && dec_ok;
    assign cmd_valid = count_reg != 2'd0;
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

FILE: rtl/kcs_back.sv
// Back end: key tables, key search, span divider, basis and multiply sequencer.
// Depends on kcs_pkg.
module kcs_back #(
    parameter int MAX_KEYS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  kcs_pkg::kcs_cmd_t    cmd,
    output logic                 cmd_pop,
    input  kcs_pkg::kcs_cfg_t    cfg,
    output logic                 result_valid,
    output kcs_pkg::kcs_result_t result
);
    import kcs_pkg::*;

    localparam int KW     = $clog2(MAX_KEYS);
    localparam int CW     = $clog2(MAX_KEYS + 1);
    localparam int VDEPTH = MAX_KEYS * WORDS_PER_KEY;
    localparam int VW     = $clog2(VDEPTH);

    logic [31:0]        tmem [MAX_KEYS];
    logic signed [31:0] vmem [VDEPTH];
    logic [31:0]        trd_reg;
    logic signed [31:0] vrd_reg;

    kcs_state_t         state_reg, state_next;
    logic [31:0]        q_reg, q_next;
    logic [CW-1:0]      keys_reg, keys_next;
    logic [1:0]         mode_reg, mode_next;
    logic [2:0]         n_reg, n_next;
    logic [KW-1:0]      j_reg, j_next;
    logic [31:0]        prev_reg, prev_next;
    logic [KW-1:0]      i_reg, i_next;
    logic               interp_reg, interp_next;
    logic [31:0]        span_reg, span_next;
    logic [31:0]        rem_reg, rem_next;
    logic [15:0]        t_reg, t_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [31:0]        tt_reg, tt_next;
    logic [47:0]        ttt_reg, ttt_next;
    logic signed [32:0] h_reg [4];
    logic signed [32:0] h_next [4];
    logic [1:0]         comp_reg, comp_next;
    logic signed [31:0] w_reg [4];
    logic signed [31:0] w_next [4];
    logic signed [31:0] m0_reg, m0_next, m1_reg, m1_next;
    logic signed [63:0] prod_reg, prod_next, acc_reg, acc_next;
    logic               res_valid_reg, res_valid_next;
    kcs_result_t        res_reg, res_next;

    logic               key_ok;
    logic               twe, vwe;
    logic [KW-1:0]      wkey;
    logic [VW-1:0]      vwa, vra;
    logic [KW-1:0]      rkey;
    logic [3:0]         rslot;
    logic [2:0]         qn;
    logic [31:0]        qkeys;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_full;
    logic [32:0]        rem2;
    logic               ge;
    logic signed [63:0] t1, t2, t3;
    logic signed [31:0] out_val;
    logic               emit;
    logic [3:0]         vbase;

    assign key_ok = 32'(cmd.key) < 32'(MAX_KEYS);
    assign wkey   = KW'(cmd.key);
    assign vwa    = VW'(wkey) * VW'(WORDS_PER_KEY) + VW'(cmd.slot);
    assign vra    = VW'(rkey) * VW'(WORDS_PER_KEY) + VW'(rslot);
    assign prod_full = mul_a * mul_b;
    assign vbase  = (mode_reg == MODE_CUBIC) ? {1'b0, n_reg} : 4'd0;

    // fetch order: value of key i, in-tangent of i+1, value of i+1, out-tangent of i
    always_comb
    begin
        rkey  = i_reg;
        rslot = vbase + 4'(comp_reg);
        case (cnt_reg[1:0])
            2'd1:
            begin
                rkey  = interp_reg ? i_reg + 1'b1 : i_reg;
                rslot = 4'(comp_reg);
            end
            2'd2:
            begin
                rkey  = interp_reg ? i_reg + 1'b1 : i_reg;
                rslot = {1'b0, n_reg} + 4'(comp_reg);
            end
            2'd3:
            begin
                rslot = {n_reg, 1'b0} + 4'(comp_reg);
            end
            default:
            begin
                rslot = vbase + 4'(comp_reg);
            end
        endcase
    end

    always_comb
    begin
        case (cfg.chan)
            CHAN_TRANS: qn = 3'd3;
            CHAN_ROT:   qn = 3'd4;
            CHAN_SCALE: qn = 3'd1;
            default:    qn = 3'd0;
        endcase
        qkeys = (cfg.key_count == 7'd0) ? 32'd1 : 32'(cfg.key_count);
        if (qkeys > 32'(MAX_KEYS))
        begin
            qkeys = 32'(MAX_KEYS);
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        q_next      = q_reg;
        keys_next   = keys_reg;
        mode_next   = mode_reg;
        n_next      = n_reg;
        j_next      = j_reg;
        prev_next   = prev_reg;
        i_next      = i_reg;
        interp_next = interp_reg;
        span_next   = span_reg;
        rem_next    = rem_reg;
        t_next      = t_reg;
        cnt_next    = cnt_reg;
        tt_next     = tt_reg;
        ttt_next    = ttt_reg;
        h_next      = h_reg;
        comp_next   = comp_reg;
        w_next      = w_reg;
        m0_next     = m0_reg;
        m1_next     = m1_reg;
        prod_next   = 64'(prod_full);
        acc_next    = acc_reg;
        res_valid_next = 1'b0;
        res_next    = res_reg;
        cmd_pop     = 1'b0;
        twe         = 1'b0;
        vwe         = 1'b0;
        mul_a       = 33'sd0;
        mul_b       = 33'sd0;
        rem2        = {rem_reg, 1'b0};
        ge          = rem2 >= {1'b0, span_reg};
        t1          = $signed(64'(t_reg)) <<< 32;
        t2          = $signed(64'(tt_reg)) <<< 16;
        t3          = $signed(64'(ttt_reg));
        out_val     = w_reg[0];
        emit        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        OP_TIME:  twe = key_ok;
                        OP_VALUE: vwe = key_ok;
                        OP_QUERY:
                        begin
                            if (qn != 3'd0)
                            begin
                                q_next      = cmd.data;
                                keys_next   = CW'(qkeys);
                                mode_next   = (cfg.mode == 2'd3) ? MODE_LINEAR : cfg.mode;
                                n_next      = qn;
                                j_next      = '0;
                                comp_next   = 2'd0;
                                interp_next = 1'b0;
                                state_next  = S_SRCH_RD;
                            end
                        end
                        default:
                        begin
                            twe = 1'b0;
                        end
                    endcase
                end
            end
            S_SRCH_RD:
            begin
                state_next = S_SRCH_CHK;
            end
            S_SRCH_CHK:
            begin
                cnt_next = 5'd0;
                if (trd_reg > q_reg)
                begin
                    if (j_reg == '0)
                    begin
                        i_next     = '0;
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        i_next    = j_reg - 1'b1;
                        span_next = trd_reg - prev_reg;
                        rem_next  = q_reg - prev_reg;
                        t_next    = 16'd0;
                        if (trd_reg != prev_reg)
                        begin
                            interp_next = 1'b1;
                            state_next  = S_DIV;
                        end
                        else
                        begin
                            state_next = S_FETCH;
                        end
                    end
                end
                else if (CW'(j_reg) == keys_reg - CW'(1))
                begin
                    // at or after the last key: hold its value, never read past it
                    i_next     = j_reg;
                    state_next = S_FETCH;
                end
                else
                begin
                    prev_next  = trd_reg;
                    j_next     = j_reg + 1'b1;
                    state_next = S_SRCH_RD;
                end
            end
            S_DIV:
            begin
                rem_next = ge ? 32'(rem2 - {1'b0, span_reg}) : rem2[31:0];
                t_next   = {t_reg[14:0], ge};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd15)
                begin
                    cnt_next   = 5'd0;
                    state_next = (mode_reg == MODE_CUBIC) ? S_BASIS : S_FETCH;
                end
            end
            S_BASIS:
            begin
                cnt_next = cnt_reg + 5'd1;
                case (cnt_reg[1:0])
                    2'd0: tt_next = 32'(t_reg) * 32'(t_reg);
                    2'd1: ttt_next = 48'(tt_reg) * 48'(t_reg);
                    default:
                    begin
                        h_next[0] = 33'(round_shift(2 * t3 - 3 * t2 + (64'sd1 <<< 48), 24));
                        h_next[1] = 33'(round_shift(t3 - 2 * t2 + t1, 24));
                        h_next[2] = 33'(round_shift(3 * t2 - 2 * t3, 24));
                        h_next[3] = 33'(round_shift(t3 - t2, 24));
                        cnt_next   = 5'd0;
                        state_next = S_FETCH;
                    end
                endcase
            end
            S_FETCH:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg != 5'd0)
                begin
                    w_next[2'(cnt_reg - 5'd1)] = vrd_reg;
                end
                if (cnt_reg == 5'd4)
                begin
                    cnt_next   = 5'd0;
                    acc_next   = 64'sd0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (!interp_reg || mode_reg == MODE_STEP)
                begin
                    emit = 1'b1;
                end
                else if (mode_reg == MODE_CUBIC)
                begin
                    case (cnt_reg[2:0])
                        3'd0:
                        begin
                            mul_a = 33'(w_reg[3]);
                            mul_b = $signed({1'b0, span_reg});
                        end
                        3'd1:
                        begin
                            m0_next = sat32(round_shift(prod_reg, 16));
                            mul_a   = 33'(w_reg[1]);
                            mul_b   = $signed({1'b0, span_reg});
                        end
                        3'd2:
                        begin
                            m1_next = sat32(round_shift(prod_reg, 16));
                            mul_a   = h_reg[0];
                            mul_b   = 33'(w_reg[0]);
                        end
                        3'd3:
                        begin
                            acc_next = prod_reg;
                            mul_a    = h_reg[1];
                            mul_b    = 33'(m0_reg);
                        end
                        3'd4:
                        begin
                            acc_next = acc_reg + prod_reg;
                            mul_a    = h_reg[2];
                            mul_b    = 33'(w_reg[2]);
                        end
                        3'd5:
                        begin
                            acc_next = acc_reg + prod_reg;
                            mul_a    = h_reg[3];
                            mul_b    = 33'(m1_reg);
                        end
                        default:
                        begin
                            out_val = sat32(round_shift(acc_reg + prod_reg, 24));
                            emit    = 1'b1;
                        end
                    endcase
                end
                else
                begin
                    case (cnt_reg[1:0])
                        2'd0:
                        begin
                            mul_a = 33'(w_reg[0]);
                            mul_b = 33'sd65536 - $signed({17'd0, t_reg});
                        end
                        2'd1:
                        begin
                            acc_next = prod_reg;
                            mul_a    = 33'(w_reg[1]);
                            mul_b    = $signed({17'd0, t_reg});
                        end
                        default:
                        begin
                            out_val = sat32(round_shift(acc_reg + prod_reg, 16));
                            emit    = 1'b1;
                        end
                    endcase
                end
                if (emit)
                begin
                    res_valid_next           = 1'b1;
                    res_next.joint           = cfg.joint;
                    res_next.component_index = comp_reg;
                    res_next.component_value = out_val;
                    res_next.last            = {1'b0, comp_reg} == n_reg - 3'd1;
                    cnt_next                 = 5'd0;
                    comp_next                = comp_reg + 2'd1;
                    state_next = ({1'b0, comp_reg} == n_reg - 3'd1) ? S_IDLE : S_FETCH;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg      <= q_next;
        keys_reg   <= keys_next;
        mode_reg   <= mode_next;
        n_reg      <= n_next;
        j_reg      <= j_next;
        prev_reg   <= prev_next;
        i_reg      <= i_next;
        interp_reg <= interp_next;
        span_reg   <= span_next;
        rem_reg    <= rem_next;
        t_reg      <= t_next;
        cnt_reg    <= cnt_next;
        tt_reg     <= tt_next;
        ttt_reg    <= ttt_next;
        h_reg      <= h_next;
        comp_reg   <= comp_next;
        w_reg      <= w_next;
        m0_reg     <= m0_next;
        m1_reg     <= m1_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        res_reg    <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (twe)
        begin
            tmem[wkey] <= cmd.data;
        end
        trd_reg <= tmem[j_reg];
    end

    always_ff @(posedge clk)
    begin
        if (vwe)
        begin
            vmem[vwa] <= $signed(cmd.data);
        end
        vrd_reg <= vmem[vra];
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

FILE: rtl/kcs_checker.sv
// Port-level checks of the keyframe channel sampler, bound to the top level.
// Depends on kcs_pkg and keyframe_channel_sampler.
module kcs_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 busy,
    input logic                 result_valid,
    input kcs_pkg::kcs_result_t result
);
    import kcs_pkg::*;

    // components of one query are spaced by the table reads
    a_no_adjacent_results: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobes in adjacent cycles");

    a_index3_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.component_index == 2'd3) |-> result.last)
        else $error("fourth component not marked last");

    a_idle_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !busy && !result_valid)
        else $error("activity right after reset");

endmodule

bind keyframe_channel_sampler kcs_checker u_kcs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

FILE: test/tb.sv
// Self-checking bench for keyframe_channel_sampler: loads key tables, runs
// directed and random queries in all modes and channel kinds, and checks each
// sampled component against a local predictor. Depends on kcs_pkg and the RTL.
module tb;
    import kcs_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    kcs_item_t   item;
    logic        result_valid;
    kcs_result_t result;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    keyframe_channel_sampler dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .result_valid(result_valid), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic [31:0]        key_times [64];
    logic signed [31:0] key_words [768];
    logic [1:0]         mode_reg;
    logic [1:0]         chan_reg;
    logic [6:0]         count_reg;
    logic [7:0]         joint_reg;

    // key times of the current random phase, for picking query times
    logic [31:0]        phase_times [64];

    kcs_item_t   pending_items [$];
    kcs_result_t expected_components [$];
    int          errors = 0;
    int          results_seen = 0;
    bit          driving_done;
    int          gap_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v, input int s);
        logic signed [63:0] x;
        x = v + (64'sd1 <<< (s - 1));
        return x >>> s;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // work out the components a query produces and queue them
    task automatic sample_channel(input logic [31:0] q);
        int n, keys, lo, mode, vbase;
        bit interp;
        logic [31:0] span;
        logic signed [63:0] t, t1, t2, t3, h00, h10, h01, h11, acc;
        logic signed [63:0] a, b, p1, m0, m1;
        kcs_result_t r;
        interp = 0;
        span = 0;
        t = 0;
        lo = 0;
        case (chan_reg)
            CHAN_TRANS: n = 3;
            CHAN_ROT:   n = 4;
            CHAN_SCALE: n = 1;
            default:    n = 0;
        endcase
        if (n == 0)
        begin
            return;
        end
        keys = (count_reg == 0) ? 1 : count_reg;
        if (keys > 64)
        begin
            keys = 64;
        end
        mode = (mode_reg == 2'd3) ? MODE_LINEAR : mode_reg;
        for (int j = 0; j < keys; j++)
        begin
            if (key_times[j] > q)
            begin
                if (j != 0)
                begin
                    lo = j - 1;
                    span = key_times[j] - key_times[lo];
                    if (span != 0)
                    begin
                        interp = 1;
                        t = $signed({32'd0, q - key_times[lo]} << 16) / $signed({32'd0, span});
                    end
                end
                break;
            end
            if (j == keys - 1)
            begin
                lo = j;
            end
        end
        vbase = (mode == MODE_CUBIC) ? n : 0;
        for (int j = 0; j < n; j++)
        begin
            a = key_words[lo * 12 + vbase + j];
            if (!interp || mode == MODE_STEP)
            begin
                r.component_value = a[31:0];
            end
            else if (mode == MODE_LINEAR)
            begin
                b = key_words[(lo + 1) * 12 + j];
                acc = a * (65536 - t) + b * t;
                r.component_value = clamp32(rnd_shift(acc, 16));
            end
            else
            begin
                t1 = t <<< 32;
                t2 = (t * t) <<< 16;
                t3 = t * t * t;
                h00 = rnd_shift(2 * t3 - 3 * t2 + (64'sd1 <<< 48), 24);
                h10 = rnd_shift(t3 - 2 * t2 + t1, 24);
                h01 = rnd_shift(-2 * t3 + 3 * t2, 24);
                h11 = rnd_shift(t3 - t2, 24);
                p1 = key_words[(lo + 1) * 12 + n + j];
                m0 = clamp32(rnd_shift(key_words[lo * 12 + 2 * n + j] * $signed({32'd0, span}), 16));
                m1 = clamp32(rnd_shift(key_words[(lo + 1) * 12 + j] * $signed({32'd0, span}), 16));
                acc = h00 * a + h10 * m0 + h01 * p1 + h11 * m1;
                r.component_value = clamp32(rnd_shift(acc, 24));
            end
            r.joint = joint_reg;
            r.component_index = j[1:0];
            r.last = (j == n - 1);
            expected_components.push_back(r);
        end
    endtask

    task automatic apply_item(input kcs_item_t it);
        case (it.kind)
            KIND_TIME:  key_times[it.key_index] = it.key_time;
            KIND_VALUE:
            begin
                if (it.slot < 12)
                begin
                    key_words[it.key_index * 12 + it.slot] = it.key_value;
                end
            end
            KIND_QUERY: sample_channel(it.query_time);
            default: ;
        endcase
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            item <= '0;
            gap_left <= 0;
        end
        else if (start && !busy)
        begin
            apply_item(item);
            if (gap_left == 0 && pending_items.size() > 0)
            begin
                item <= pending_items.pop_front();
                gap_left <= $urandom_range(0, 9) == 0 ? 0 : $urandom_range(0, 9);
            end
            else
            begin
                start <= 1'b0;
            end
        end
        else if (!start)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
            end
            else if (pending_items.size() > 0)
            begin
                start <= 1'b1;
                item <= pending_items.pop_front();
                gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9);
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            results_seen <= results_seen + 1;
            if (expected_components.size() == 0)
            begin
                $error("unexpected component value %h", result.component_value);
                errors++;
            end
            else
            begin
                kcs_result_t e;
                e = expected_components.pop_front();
                if (result.joint !== e.joint)
                begin
                    $error("joint exp %0d got %0d", e.joint, result.joint);
                    errors++;
                end
                if (result.component_index !== e.component_index)
                begin
                    $error("component_index exp %0d got %0d", e.component_index,
                           result.component_index);
                    errors++;
                end
                if (result.component_value !== e.component_value)
                begin
                    $error("component_value exp %h got %h", e.component_value,
                           result.component_value);
                    errors++;
                end
                if (result.last !== e.last)
                begin
                    $error("last exp %0d got %0d", e.last, result.last);
                    errors++;
                end
            end
        end
    end

    function automatic kcs_item_t make_item(input logic [1:0] k, input int key, input int slot,
                                            input logic [31:0] data);
        kcs_item_t it;
        it.kind = k;
        it.key_index = key[5:0];
        it.slot = slot[3:0];
        it.key_time = $urandom;
        it.key_value = $urandom;
        it.query_time = $urandom;
        if (k == KIND_TIME)
        begin
            it.key_time = data;
        end
        if (k == KIND_VALUE)
        begin
            it.key_value = data;
        end
        if (k == KIND_QUERY)
        begin
            it.query_time = data;
        end
        return it;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(0, 1) ? 32'hFFFFFFFF : 32'h0;
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    // wait for quiet, then write a register
    task automatic set_reg(input logic [1:0] idx, input logic [7:0] val);
        wait (pending_items.size() == 0 && !start && expected_components.size() == 0);
        repeat (120) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MODE:  mode_reg = val[1:0];
            REG_CHAN:  chan_reg = val[1:0];
            REG_COUNT: count_reg = val[6:0];
            default:   joint_reg = val;
        endcase
    endtask

    // all 64 key times; value words only for keys 0 to 5 and key 63, which
    // are the only keys a query below the sixth key time or past the last
    // key can land on
    task automatic load_directed();
        logic [31:0] tm;
        for (int k = 0; k < 64; k++)
        begin
            tm = (k < 6) ? 32'(k) * 32'h10000 + 32'h800 : 32'h100000 + 32'(k) * 32'h3000;
            pending_items.push_back(make_item(KIND_TIME, k, $urandom_range(0, 15), tm));
            if (k < 6 || k == 63)
            begin
                for (int s = 0; s < 12; s++)
                begin
                    pending_items.push_back(make_item(KIND_VALUE, k, s, rand_word()));
                end
            end
        end
    endtask

    // queries before the sixth key time, at zero or at the far end
    task automatic directed_queries(input int cnt);
        logic [31:0] q;
        for (int i = 0; i < cnt; i++)
        begin
            case ($urandom_range(0, 3))
                0:       q = 32'hFFFFFFFF;
                1:       q = 32'h0;
                default: q = $urandom_range(0, 32'h507FF);
            endcase
            pending_items.push_back(make_item(KIND_QUERY, $urandom, $urandom, q));
        end
    endtask

    // load times (sorted unless told otherwise) and all value words of nkeys keys
    task automatic load_keys(input int nkeys, input bit sorted);
        logic [31:0] tm;
        logic [31:0] kt;
        tm = $urandom_range(0, 3) == 0 ? 32'd0 : $urandom_range(0, 32'h40000);
        for (int k = 0; k < nkeys; k++)
        begin
            kt = sorted ? tm : $urandom;
            phase_times[k] = kt;
            pending_items.push_back(make_item(KIND_TIME, k, $urandom_range(0, 15), kt));
            tm = tm + ($urandom_range(0, 7) == 0 ? $urandom_range(0, 3) :
                       $urandom_range(1, 32'h30000));
            for (int s = 0; s < 12; s++)
            begin
                pending_items.push_back(make_item(KIND_VALUE, k, s, rand_word()));
            end
        end
    endtask

    task automatic queries(input int cnt, input int nkeys);
        logic [31:0] q;
        for (int i = 0; i < cnt; i++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                q = $urandom_range(0, 1) ? 32'hFFFFFFFF : 32'h0;
            end
            else
            begin
                q = phase_times[$urandom_range(0, nkeys - 1)] + $urandom_range(0, 32'h30000)
                    - 32'h8000;
            end
            pending_items.push_back(make_item(KIND_QUERY, $urandom, $urandom, q));
        end
    endtask

    initial
    begin
        int nkeys;
        int done;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mode_reg = MODE_LINEAR;
        chan_reg = CHAN_TRANS;
        count_reg = 7'd1;
        joint_reg = 8'd0;
        for (int i = 0; i < 64; i++)
        begin
            key_times[i] = 0;
            phase_times[i] = 0;
        end
        for (int i = 0; i < 768; i++)
        begin
            key_words[i] = 0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: all 64 key times, query edges with reset settings
        load_directed();
        // ignored writes: slot above 11, kind 3
        pending_items.push_back(make_item(KIND_VALUE, 5, 15, 32'h12345678));
        pending_items.push_back(make_item(2'd3, 63, 12, 32'hFFFFFFFF));
        pending_items.push_back(make_item(KIND_QUERY, 0, 0, 32'h0));
        pending_items.push_back(make_item(KIND_QUERY, 0, 0, 32'hFFFFFFFF));
        // extreme mode / channel / count combinations
        for (int m = 0; m < 4; m++)
        begin
            set_reg(REG_MODE, m);
            for (int c = 0; c < 4; c++)
            begin
                set_reg(REG_CHAN, c);
                set_reg(REG_COUNT, (c == 0) ? 0 : (c == 1) ? 127 : (c == 2) ? 64 : 2);
                set_reg(REG_JOINT, (c == 3) ? 8'hFF : $urandom_range(0, 255));
                directed_queries(2);
            end
        end

        // random phases; the sender pauses for all results between phases
        done = 0;
        while (done < 40)
        begin
            nkeys = $urandom_range(2, 4);
            set_reg(REG_MODE, $urandom_range(0, 3));
            set_reg(REG_CHAN, $urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2));
            set_reg(REG_COUNT, $urandom_range(0, 9) == 0 ? 0 : nkeys);
            set_reg(REG_JOINT, $urandom_range(0, 255));
            wait (pending_items.size() == 0 && !start && expected_components.size() == 0);
            load_keys(nkeys, $urandom_range(0, 7) != 0);
            queries(10, nkeys);
            done += 10;
        end

        wait (pending_items.size() == 0 && !start && expected_components.size() == 0);
        repeat (300) @(posedge clk);
        if (errors == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial
    begin
        #20000000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule

FILE: files.f
rtl/kcs_pkg.sv
rtl/kcs_front.sv
rtl/kcs_back.sv
rtl/keyframe_channel_sampler.sv
rtl/kcs_checker.sv
test/tb.sv
